// ===== src/glr_pkg.sv =====
// ----------------------------------------------------------------------------
// glr_pkg
// shared constants, command and result types of the gradient line rasterizer
// ----------------------------------------------------------------------------
package glr_pkg;

    localparam int COORD_BITS    = 13;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    localparam int CH_BITS     = 8;
    localparam int NUM_CH      = 3;
    localparam int PIX_BITS    = 12;
    localparam int DELTA_BITS  = COORD_BITS + 1;   // end minus start
    localparam int N_BITS      = COORD_BITS;       // step count, |delta| max
    localparam int ERR_BITS    = COORD_BITS + 2;   // remainder plus delta
    localparam int CDELTA_BITS = CH_BITS + 1;      // signed colour delta
    localparam int CSUM_BITS   = CH_BITS + 2;      // colour plus signed step
    localparam int DIV_STEPS   = CH_BITS;          // one quotient bit a cycle
    localparam int CNT_BITS    = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COORD_BITS-1:0] SCREEN_W = COORD_BITS'(SCREEN_WIDTH);
    localparam logic [COORD_BITS-1:0] SCREEN_H = COORD_BITS'(SCREEN_HEIGHT);

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } t_back_state;

    // classified request handed from front to back
    typedef struct packed {
        t_action                                action;
        logic signed [DELTA_BITS-1:0]           dx;
        logic signed [DELTA_BITS-1:0]           dy;
        logic        [N_BITS-1:0]               n;
        logic signed [COORD_BITS-1:0]           x0;
        logic signed [COORD_BITS-1:0]           y0;
        logic        [NUM_CH-1:0][CH_BITS-1:0]  c0;
        logic        [NUM_CH-1:0]               cneg;
        logic        [NUM_CH-1:0][CH_BITS-1:0]  cmag;
    } t_cmd;

    typedef struct packed {
        logic                              pixel_valid;
        logic [PIX_BITS-1:0]               pixel_x;
        logic [PIX_BITS-1:0]               pixel_y;
        logic [NUM_CH-1:0][CH_BITS-1:0]    colour;
        logic                              line_done;
    } t_result;

endpackage

// ===== src/glr_front.sv =====
// ----------------------------------------------------------------------------
// glr_front
// accepts requests, forms deltas, step count and colour deltas
// ----------------------------------------------------------------------------
module glr_front (
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic                                    i_action,
    input  logic signed [glr_pkg::COORD_BITS-1:0]   i_start_x,
    input  logic signed [glr_pkg::COORD_BITS-1:0]   i_start_y,
    input  logic signed [glr_pkg::COORD_BITS-1:0]   i_end_x,
    input  logic signed [glr_pkg::COORD_BITS-1:0]   i_end_y,
    input  logic [glr_pkg::CH_BITS-1:0]             i_start_red,
    input  logic [glr_pkg::CH_BITS-1:0]             i_start_green,
    input  logic [glr_pkg::CH_BITS-1:0]             i_start_blue,
    input  logic [glr_pkg::CH_BITS-1:0]             i_end_red,
    input  logic [glr_pkg::CH_BITS-1:0]             i_end_green,
    input  logic [glr_pkg::CH_BITS-1:0]             i_end_blue,
    input  logic                                    i_queue_full,
    output logic                                    o_push,
    output glr_pkg::t_cmd                           o_cmd
);
    import glr_pkg::*;

    logic signed [DELTA_BITS-1:0]    dx;
    logic signed [DELTA_BITS-1:0]    dy;
    logic        [N_BITS-1:0]        ax;
    logic        [N_BITS-1:0]        ay;
    logic        [CH_BITS-1:0]       cs [NUM_CH];
    logic        [CH_BITS-1:0]       ce [NUM_CH];
    logic signed [CDELTA_BITS-1:0]   cd [NUM_CH];
    logic signed [CDELTA_BITS-1:0]   cd_abs [NUM_CH];

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    assign cs[0] = i_start_red;
    assign cs[1] = i_start_green;
    assign cs[2] = i_start_blue;
    assign ce[0] = i_end_red;
    assign ce[1] = i_end_green;
    assign ce[2] = i_end_blue;

    always_comb begin
        dx = DELTA_BITS'(i_end_x) - DELTA_BITS'(i_start_x);
        dy = DELTA_BITS'(i_end_y) - DELTA_BITS'(i_start_y);
        ax = dx[DELTA_BITS-1] ? N_BITS'(-dx) : N_BITS'(dx);
        ay = dy[DELTA_BITS-1] ? N_BITS'(-dy) : N_BITS'(dy);

        o_cmd        = '0;
        o_cmd.action = t_action'(i_action);
        o_cmd.dx     = dx;
        o_cmd.dy     = dy;
        o_cmd.n      = (ax > ay) ? ax : ay;
        o_cmd.x0     = i_start_x;
        o_cmd.y0     = i_start_y;
        for (int c = 0; c < NUM_CH; c++) begin
            cd[c]         = $signed({1'b0, ce[c]}) - $signed({1'b0, cs[c]});
            cd_abs[c]     = cd[c][CDELTA_BITS-1] ? -cd[c] : cd[c];
            o_cmd.c0[c]   = cs[c];
            o_cmd.cneg[c] = cd[c][CDELTA_BITS-1];
            o_cmd.cmag[c] = cd_abs[c][CH_BITS-1:0];
        end
    end

endmodule

// ===== src/glr_queue.sv =====
// ----------------------------------------------------------------------------
// glr_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module glr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  glr_pkg::t_cmd   i_cmd,
    output logic            o_full,
    output logic            o_not_empty,
    input  logic            i_pop,
    output glr_pkg::t_cmd   o_cmd
);
    import glr_pkg::*;

    t_cmd                  r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr;
    logic [QPTR_BITS-1:0]  r_rd;
    logic [QCNT_BITS-1:0]  r_count;
    logic                  do_pop;

    assign o_full      = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd];
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== src/glr_back.sv =====
// ----------------------------------------------------------------------------
// glr_back
// line state, colour step divider, pixel stepping and output register
// ----------------------------------------------------------------------------
module glr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  glr_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output glr_pkg::t_result   o_res
);
    import glr_pkg::*;

    t_back_state                   r_state;
    t_back_state                   n_state;
    logic                          r_line_active;
    logic [N_BITS-1:0]             r_n;
    logic [N_BITS-1:0]             r_idx;
    logic signed [DELTA_BITS-1:0]  r_dx;
    logic signed [DELTA_BITS-1:0]  r_dy;
    logic signed [COORD_BITS-1:0]  r_pos_x;
    logic signed [COORD_BITS-1:0]  r_pos_y;
    logic [N_BITS-1:0]             r_err_x;
    logic [N_BITS-1:0]             r_err_y;
    logic [CH_BITS-1:0]            r_cnow  [NUM_CH];
    logic [N_BITS-1:0]             r_cerr  [NUM_CH];
    logic signed [CDELTA_BITS-1:0] r_cstep [NUM_CH];
    logic [N_BITS-1:0]             r_crem  [NUM_CH];
    logic [CH_BITS-1:0]            r_quo   [NUM_CH];
    logic [N_BITS-1:0]             r_rem   [NUM_CH];
    logic [NUM_CH-1:0]             r_neg;
    logic [CNT_BITS-1:0]           r_cnt;
    logic                          r_out_valid;
    t_result                       r_out;

    logic                          out_free;
    logic                          pop;
    logic                          emit;
    t_result                       n_res;

    logic signed [ERR_BITS-1:0]    ex;
    logic signed [ERR_BITS-1:0]    ey;
    logic signed [ERR_BITS-1:0]    n_ext;
    logic [N_BITS-1:0]             n_err_x;
    logic [N_BITS-1:0]             n_err_y;
    logic signed [COORD_BITS-1:0]  n_pos_x;
    logic signed [COORD_BITS-1:0]  n_pos_y;
    logic                          on_screen;
    logic [N_BITS:0]               idx_inc;
    logic                          last_step;
    logic signed [CSUM_BITS-1:0]   csum    [NUM_CH];
    logic [N_BITS:0]               esum    [NUM_CH];
    logic [CH_BITS-1:0]            n_cnow  [NUM_CH];
    logic [N_BITS-1:0]             n_cerr  [NUM_CH];
    logic [N_BITS:0]               trial   [NUM_CH];
    logic                          qbit    [NUM_CH];
    logic [N_BITS-1:0]             n_rem   [NUM_CH];
    logic signed [CDELTA_BITS-1:0] fin_q   [NUM_CH];
    logic [N_BITS-1:0]             fin_r   [NUM_CH];

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free && i_cmd.action == ACT_LOAD && i_cmd.n != '0) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_cnt == '0) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop  = 1'b0;
        emit = 1'b0;
        case (r_state)
            BK_IDLE: begin
                pop  = i_cmd_valid && out_free;
                emit = pop && (i_cmd.action == ACT_STEP || i_cmd.n == '0);
            end
            BK_EMIT: emit = out_free;
            BK_DIV:  emit = 1'b0;
            default: emit = 1'b0;
        endcase
    end

    assign o_cmd_pop = pop;

    // stepping datapath
    always_comb begin
        n_ext = ERR_BITS'($signed({1'b0, r_n}));
        ex = ERR_BITS'($signed({1'b0, r_err_x})) + ERR_BITS'(r_dx);
        ey = ERR_BITS'($signed({1'b0, r_err_y})) + ERR_BITS'(r_dy);

        n_pos_x = r_pos_x;
        n_err_x = N_BITS'(ex);
        if (ex >= n_ext) begin
            n_err_x = N_BITS'(ex - n_ext);
            n_pos_x = r_pos_x + 1'b1;
        end else if (ex[ERR_BITS-1]) begin
            n_err_x = N_BITS'(ex + n_ext);
            n_pos_x = r_pos_x - 1'b1;
        end

        n_pos_y = r_pos_y;
        n_err_y = N_BITS'(ey);
        if (ey >= n_ext) begin
            n_err_y = N_BITS'(ey - n_ext);
            n_pos_y = r_pos_y + 1'b1;
        end else if (ey[ERR_BITS-1]) begin
            n_err_y = N_BITS'(ey + n_ext);
            n_pos_y = r_pos_y - 1'b1;
        end

        on_screen = !n_pos_x[COORD_BITS-1] && (n_pos_x < $signed(SCREEN_W))
                 && !n_pos_y[COORD_BITS-1] && (n_pos_y < $signed(SCREEN_H));

        idx_inc   = {1'b0, r_idx} + 1'b1;
        last_step = (idx_inc == {1'b0, r_n});

        for (int c = 0; c < NUM_CH; c++) begin
            csum[c] = $signed({2'b00, r_cnow[c]}) + CSUM_BITS'(r_cstep[c]);
            esum[c] = {1'b0, r_cerr[c]} + {1'b0, r_crem[c]};
            n_cerr[c] = N_BITS'(esum[c]);
            if (esum[c] >= {1'b0, r_n}) begin
                n_cerr[c] = N_BITS'(esum[c] - {1'b0, r_n});
                csum[c]   = csum[c] + 1'b1;
            end
            n_cnow[c] = csum[c][CH_BITS-1:0];
        end
    end

    // restoring divider step and floor correction
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            trial[c] = {r_rem[c], r_quo[c][CH_BITS-1]};
            qbit[c]  = (trial[c] >= {1'b0, r_n});
            n_rem[c] = qbit[c] ? N_BITS'(trial[c] - {1'b0, r_n}) : N_BITS'(trial[c]);

            if (!r_neg[c]) begin
                fin_q[c] = $signed({1'b0, r_quo[c]});
                fin_r[c] = r_rem[c];
            end else if (r_rem[c] == '0) begin
                fin_q[c] = -$signed({1'b0, r_quo[c]});
                fin_r[c] = '0;
            end else begin
                fin_q[c] = -$signed({1'b0, r_quo[c]}) - 1'b1;
                fin_r[c] = r_n - r_rem[c];
            end
        end
    end

    // result formatting
    always_comb begin
        n_res = '0;
        if (r_state == BK_IDLE) begin
            if (i_cmd.action == ACT_LOAD) begin
                n_res.line_done = 1'b1;
            end else if (!r_line_active) begin
                n_res.line_done = 1'b1;
            end else begin
                n_res.line_done = last_step;
                if (on_screen) begin
                    n_res.pixel_valid = 1'b1;
                    n_res.pixel_x     = n_pos_x[PIX_BITS-1:0];
                    n_res.pixel_y     = n_pos_y[PIX_BITS-1:0];
                    for (int c = 0; c < NUM_CH; c++) begin
                        n_res.colour[c] = r_cnow[c];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (pop) begin
                if (i_cmd.action == ACT_LOAD) begin
                    r_line_active <= 1'b0;
                    r_cnt         <= CNT_BITS'(DIV_STEPS - 1);
                end else if (r_line_active && last_step) begin
                    r_line_active <= 1'b0;
                end
            end else if (r_state == BK_DIV) begin
                r_cnt <= r_cnt - 1'b1;
            end else if (r_state == BK_EMIT && out_free) begin
                r_line_active <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= n_res;
        end
        if (pop) begin
            if (i_cmd.action == ACT_LOAD) begin
                r_n     <= i_cmd.n;
                r_idx   <= '0;
                r_dx    <= i_cmd.dx;
                r_dy    <= i_cmd.dy;
                r_pos_x <= i_cmd.x0;
                r_pos_y <= i_cmd.y0;
                r_err_x <= '0;
                r_err_y <= '0;
                r_neg   <= i_cmd.cneg;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_cnow[c] <= i_cmd.c0[c];
                    r_cerr[c] <= '0;
                    r_quo[c]  <= i_cmd.cmag[c];
                    r_rem[c]  <= '0;
                end
            end else if (r_line_active) begin
                r_idx   <= N_BITS'(idx_inc);
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_err_x <= n_err_x;
                r_err_y <= n_err_y;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_cnow[c] <= n_cnow[c];
                    r_cerr[c] <= n_cerr[c];
                end
            end
        end else if (r_state == BK_DIV) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_rem[c] <= n_rem[c];
                r_quo[c] <= {r_quo[c][CH_BITS-2:0], qbit[c]};
            end
        end else if (r_state == BK_EMIT && out_free) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_cstep[c] <= fin_q[c];
                r_crem[c]  <= fin_r[c];
            end
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_n != '0) && !r_line_active)
        else $error("divider running without a valid step count");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_idx < r_n) && (r_err_x < r_n) && (r_err_y < r_n))
        else $error("active line index or error term out of range");

    a_colour_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_cerr[0] < r_n) && (r_cerr[1] < r_n) && (r_cerr[2] < r_n))
        else $error("colour error term out of range");

    a_pixel_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pixel_valid) |->
            (r_out.pixel_x < PIX_BITS'(SCREEN_WIDTH)) &&
            (r_out.pixel_y < PIX_BITS'(SCREEN_HEIGHT)))
        else $error("pixel marked valid outside the screen");

endmodule

// ===== src/gradient_line_rasterizer.sv =====
// step requests: one result per request, registered in the queue and then in the output register
// steps stream at one per cycle through the two-entry queue and the output register while i_ready stays high
// a load with a nonzero length holds the back end: it enters the bit-serial colour step
// divider from BK_IDLE, runs it in BK_DIV and finalizes the step in BK_EMIT
// a zero-length load or a step with no active line answers straight from BK_IDLE, like a step
// synchronous active-low reset empties the queue and output register, no line active
// ----------------------------------------------------------------------------
// gradient_line_rasterizer
// line stepper with exact per-pixel colour interpolation
// ----------------------------------------------------------------------------
module gradient_line_rasterizer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // request channel
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic                                    i_action,
    input  logic signed [glr_pkg::COORD_BITS-1:0]   i_start_x,
    input  logic signed [glr_pkg::COORD_BITS-1:0]   i_start_y,
    input  logic signed [glr_pkg::COORD_BITS-1:0]   i_end_x,
    input  logic signed [glr_pkg::COORD_BITS-1:0]   i_end_y,
    input  logic [glr_pkg::CH_BITS-1:0]             i_start_red,
    input  logic [glr_pkg::CH_BITS-1:0]             i_start_green,
    input  logic [glr_pkg::CH_BITS-1:0]             i_start_blue,
    input  logic [glr_pkg::CH_BITS-1:0]             i_end_red,
    input  logic [glr_pkg::CH_BITS-1:0]             i_end_green,
    input  logic [glr_pkg::CH_BITS-1:0]             i_end_blue,
    // result channel
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic                                    o_pixel_valid,
    output logic [glr_pkg::PIX_BITS-1:0]            o_pixel_x,
    output logic [glr_pkg::PIX_BITS-1:0]            o_pixel_y,
    output logic [glr_pkg::CH_BITS-1:0]             o_red,
    output logic [glr_pkg::CH_BITS-1:0]             o_green,
    output logic [glr_pkg::CH_BITS-1:0]             o_blue,
    output logic                                    o_line_done
);
    import glr_pkg::*;

    // front to queue
    logic     push;
    logic     queue_full;
    t_cmd     front_cmd;

    // queue to back
    logic     queue_not_empty;
    logic     back_pop;
    t_cmd     queue_cmd;

    t_result  res;

    // classify the request: deltas, step count and colour deltas
    glr_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_start_red   (i_start_red),
        .i_start_green (i_start_green),
        .i_start_blue  (i_start_blue),
        .i_end_red     (i_end_red),
        .i_end_green   (i_end_green),
        .i_end_blue    (i_end_blue),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // decouples acceptance from a back end busy dividing or stalled on output
    glr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .o_full      (queue_full),
        .o_not_empty (queue_not_empty),
        .i_pop       (back_pop),
        .o_cmd       (queue_cmd)
    );

    // line state, divider for the colour steps, error-term stepping
    glr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_not_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (back_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

    // result fields out of the registered result
    assign o_pixel_valid = res.pixel_valid;
    assign o_pixel_x     = res.pixel_x;
    assign o_pixel_y     = res.pixel_y;
    assign o_red         = res.colour[0];
    assign o_green       = res.colour[1];
    assign o_blue        = res.colour[2];
    assign o_line_done   = res.line_done;

endmodule

// ===== dv/tb_gradient_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// tb_gradient_line_rasterizer
// drives line loads and pixel steps into the rasterizer and compares every
// result, field by field, with an exact error-term model of the line stepper;
// random idling on both channels and one long output stall
// ----------------------------------------------------------------------------
module tb_gradient_line_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import glr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 30;      // a nonzero load keeps the back end busy in the divider

    // one request as offered on the input channel
    typedef struct packed {
        t_action                        act;
        logic signed [COORD_BITS-1:0]   sx;
        logic signed [COORD_BITS-1:0]   sy;
        logic signed [COORD_BITS-1:0]   ex;
        logic signed [COORD_BITS-1:0]   ey;
        logic [0:NUM_CH-1][CH_BITS-1:0] c_start;   // red, green, blue
        logic [0:NUM_CH-1][CH_BITS-1:0] c_end;
    } t_line_req;

    // one result as seen on the output channel
    typedef struct packed {
        logic                           draw;
        logic [PIX_BITS-1:0]            px;
        logic [PIX_BITS-1:0]            py;
        logic [0:NUM_CH-1][CH_BITS-1:0] rgb;
        logic                           done;
    } t_pixel;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_action;
    logic signed [COORD_BITS-1:0]  i_start_x;
    logic signed [COORD_BITS-1:0]  i_start_y;
    logic signed [COORD_BITS-1:0]  i_end_x;
    logic signed [COORD_BITS-1:0]  i_end_y;
    logic [CH_BITS-1:0]            i_start_red;
    logic [CH_BITS-1:0]            i_start_green;
    logic [CH_BITS-1:0]            i_start_blue;
    logic [CH_BITS-1:0]            i_end_red;
    logic [CH_BITS-1:0]            i_end_green;
    logic [CH_BITS-1:0]            i_end_blue;
    logic                          o_valid;
    logic                          i_ready;
    logic                          o_pixel_valid;
    logic [PIX_BITS-1:0]           o_pixel_x;
    logic [PIX_BITS-1:0]           o_pixel_y;
    logic [CH_BITS-1:0]            o_red;
    logic [CH_BITS-1:0]            o_green;
    logic [CH_BITS-1:0]            o_blue;
    logic                          o_line_done;

    gradient_line_rasterizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_start_red   (i_start_red),
        .i_start_green (i_start_green),
        .i_start_blue  (i_start_blue),
        .i_end_red     (i_end_red),
        .i_end_green   (i_end_green),
        .i_end_blue    (i_end_blue),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_line_done   (o_line_done)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // line stepper model, all state starts at zero, no line live as in the block after reset
    // ------------------------------------------------------------------------
    bit  ln_live;
    int  ln_len;                 // N, the larger axis distance
    int  ln_idx;                 // pixels emitted so far
    int  cur [2];                // x, y position
    int  rem [2];                // axis remainders, kept in [0,N)
    int  run [2];                // signed axis deltas
    int  shade [NUM_CH];         // current channel values
    int  shade_frac [NUM_CH];    // channel remainders in [0,N)
    int  shade_inc [NUM_CH];     // floor((end - start) / N)
    int  shade_mod [NUM_CH];     // matching nonnegative remainder

    t_pixel pending_pixels [$];  // results owed by the block, oldest first

    bit  idle_on = 1'b1;         // random bursts of idling on both sides
    bit  offering = 1'b0;        // i_valid is being held high by the sender
    int  hold_cycles = 0;        // long receiver hold-off, counted down by the sink
    int  requests_sent = 0;
    int  results_seen = 0;
    int  lines_loaded = 0;
    int  pixels_drawn = 0;
    int  pixels_clipped = 0;
    int  idle_steps = 0;
    int  mismatches = 0;
    int  cycle_count = 0;

    function automatic t_pixel rasterize_request(t_line_req r);
        t_pixel px;
        int     d;
        int     q;
        int     m;
        int     a;
        int     c;
        px = '0;
        if (r.act == ACT_LOAD) begin
            run[0] = int'($signed(r.ex)) - int'($signed(r.sx));
            run[1] = int'($signed(r.ey)) - int'($signed(r.sy));
            cur[0] = int'($signed(r.sx));
            cur[1] = int'($signed(r.sy));
            rem[0] = 0;
            rem[1] = 0;
            ln_len = (run[0] < 0) ? -run[0] : run[0];
            d = (run[1] < 0) ? -run[1] : run[1];
            if (d > ln_len)
                ln_len = d;
            ln_idx = 0;
            for (c = 0; c < NUM_CH; c++) begin
                shade[c] = int'(r.c_start[c]);
                shade_frac[c] = 0;
                shade_inc[c] = 0;
                shade_mod[c] = 0;
                if (ln_len > 0) begin
                    // floor division with a nonnegative remainder
                    d = int'(r.c_end[c]) - int'(r.c_start[c]);
                    q = d / ln_len;
                    m = d - q * ln_len;
                    if (m < 0) begin
                        m += ln_len;
                        q -= 1;
                    end
                    shade_inc[c] = q;
                    shade_mod[c] = m;
                end
            end
            ln_live = (ln_len > 0);
            px.done = !ln_live;
            if (ln_live)
                lines_loaded++;
            return px;
        end

        if (!ln_live) begin
            idle_steps++;
            px.done = 1'b1;
            return px;
        end

        for (a = 0; a < 2; a++) begin
            rem[a] += run[a];
            if (rem[a] >= ln_len) begin
                rem[a] -= ln_len;
                cur[a] += 1;
            end else if (rem[a] < 0) begin
                rem[a] += ln_len;
                cur[a] -= 1;
            end
        end

        if (cur[0] >= 0 && cur[0] < SCREEN_WIDTH && cur[1] >= 0 && cur[1] < SCREEN_HEIGHT) begin
            px.draw = 1'b1;
            px.px = PIX_BITS'(cur[0]);
            px.py = PIX_BITS'(cur[1]);
            for (c = 0; c < NUM_CH; c++)
                px.rgb[c] = CH_BITS'(shade[c]);
            pixels_drawn++;
        end else begin
            pixels_clipped++;
        end

        for (c = 0; c < NUM_CH; c++) begin
            shade[c] += shade_inc[c];
            shade_frac[c] += shade_mod[c];
            if (shade_frac[c] >= ln_len) begin
                shade_frac[c] -= ln_len;
                shade[c] += 1;
            end
        end

        ln_idx++;
        if (ln_idx >= ln_len) begin
            ln_live = 1'b0;
            px.done = 1'b1;
        end
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------------
    // every field random; steps ignore the payload, so it is noise there
    function automatic t_line_req random_req(t_action act);
        t_line_req r;
        int        c;
        r.act = act;
        r.sx = COORD_BITS'($urandom);
        r.sy = COORD_BITS'($urandom);
        r.ex = COORD_BITS'($urandom);
        r.ey = COORD_BITS'($urandom);
        for (c = 0; c < NUM_CH; c++) begin
            r.c_start[c] = CH_BITS'($urandom);
            r.c_end[c] = CH_BITS'($urandom);
        end
        return r;
    endfunction

    // colours given as 24'hRRGGBB
    function automatic t_line_req line_of(int sx, int sy, int ex, int ey,
                                          logic [23:0] cs, logic [23:0] ce);
        t_line_req r;
        r.act = ACT_LOAD;
        r.sx = COORD_BITS'(sx);
        r.sy = COORD_BITS'(sy);
        r.ex = COORD_BITS'(ex);
        r.ey = COORD_BITS'(ey);
        r.c_start = cs;
        r.c_end = ce;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side: optional idle burst, then hold valid until accepted
    // valid is left high on return so back-to-back requests keep it up
    // ------------------------------------------------------------------------
    task automatic send_request(t_line_req r);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            if (offering) begin
                i_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_action      <= r.act;
        i_start_x     <= r.sx;
        i_start_y     <= r.sy;
        i_end_x       <= r.ex;
        i_end_y       <= r.ey;
        i_start_red   <= r.c_start[0];
        i_start_green <= r.c_start[1];
        i_start_blue  <= r.c_start[2];
        i_end_red     <= r.c_end[0];
        i_end_green   <= r.c_end[1];
        i_end_blue    <= r.c_end[2];
        i_valid       <= 1'b1;
        offering = 1'b1;
        do
            @(posedge i_clk);
        while (!o_ready);
        pending_pixels.push_back(rasterize_request(r));
        requests_sent++;
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall bursts plus the long hold-off when ordered
    // ------------------------------------------------------------------------
    initial begin : pixel_sink
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // every accepted result against the oldest owed one
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_pixels.size() == 0) begin
                $display("%0t: result with nothing owed, expected none, actual x=%0d y=%0d",
                         $time, o_pixel_x, o_pixel_y);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_valid", int'(want.draw), int'(o_pixel_valid));
                check_field("pixel_x", int'(want.px), int'(o_pixel_x));
                check_field("pixel_y", int'(want.py), int'(o_pixel_y));
                check_field("red", int'(want.rgb[0]), int'(o_red));
                check_field("green", int'(want.rgb[1]), int'(o_green));
                check_field("blue", int'(want.rgb[2]), int'(o_blue));
                check_field("line_done", int'(want.done), int'(o_line_done));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_pixels.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // steps straight after reset, no line loaded yet
    task automatic test_idle_steps();
        send_request(random_req(ACT_STEP));
        send_request(random_req(ACT_STEP));
    endtask

    // short lines, a zero-length load and a step past the end
    task automatic test_short_lines();
        int k;
        send_request(line_of(0, 0, 3, 1, 24'h00FF80, 24'hFF0080));
        for (k = 0; k < 3; k++)
            send_request(random_req(ACT_STEP));
        send_request(line_of(100, 100, 100, 100, 24'hFFFFFF, 24'h000000));
        send_request(random_req(ACT_STEP));
        send_request(line_of(-1, -1, 0, 0, 24'h000000, 24'hFFFFFF));
        send_request(random_req(ACT_STEP));
        send_request(random_req(ACT_STEP));
    endtask

    // coordinate extremes, clipping at the screen edges, replacing a live line
    task automatic test_clip_and_replace();
        int k;
        send_request(line_of(-4096, -4096, 4095, 4095, 24'hFFFFFF, 24'h000000));
        send_request(random_req(ACT_STEP));
        send_request(random_req(ACT_STEP));
        // abandons the long line, crosses the right and top edges
        send_request(line_of(641, -2, 636, 2, 24'h0000FF, 24'hFF00FF));
        for (k = 0; k < 5; k++)
            send_request(random_req(ACT_STEP));
        // ends on the bottom-right screen corner region
        send_request(line_of(639, 476, 637, 479, 24'hFF00FF, 24'h00FF00));
        for (k = 0; k < 3; k++)
            send_request(random_req(ACT_STEP));
    endtask

    // receiver holds off while steps keep coming, so the block backs up
    task automatic test_output_stall();
        int k;
        idle_on = 1'b0;
        send_request(line_of(5, 5, 55, 30, 24'h00FF00, 24'hFF00FF));
        hold_cycles = 200;
        for (k = 0; k < 50; k++)
            send_request(random_req(ACT_STEP));
        idle_on = 1'b1;
    endtask

    // mostly whole short lines near the screen, some long random ones,
    // some cut short by the next load and some stepped past the end
    task automatic test_random_lines(int budget);
        t_line_req r;
        int        first;
        int        steps;
        int        k;
        int        x0;
        int        y0;
        first = requests_sent;
        while (requests_sent - first < budget) begin
            r = random_req(ACT_LOAD);
            if ($urandom_range(0, 9) != 0) begin
                x0 = $urandom_range(0, 700) - 30;
                y0 = $urandom_range(0, 540) - 30;
                r.sx = COORD_BITS'(x0);
                r.sy = COORD_BITS'(y0);
                if ($urandom_range(0, 19) == 0) begin
                    r.ex = COORD_BITS'(x0);
                    r.ey = COORD_BITS'(y0);
                end else begin
                    r.ex = COORD_BITS'(x0 + int'($urandom_range(0, 40)) - 20);
                    r.ey = COORD_BITS'(y0 + int'($urandom_range(0, 40)) - 20);
                end
            end
            send_request(r);
            if (ln_len > 40) begin
                steps = $urandom_range(0, 6);
            end else begin
                case ($urandom_range(0, 9))
                    0: steps = $urandom_range(0, ln_len);
                    1: steps = ln_len + $urandom_range(1, 2);
                    default: steps = ln_len;
                endcase
            end
            for (k = 0; k < steps; k++)
                send_request(random_req(ACT_STEP));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = ACT_LOAD;
        i_start_x     = '0;
        i_start_y     = '0;
        i_end_x       = '0;
        i_end_y       = '0;
        i_start_red   = '0;
        i_start_green = '0;
        i_start_blue  = '0;
        i_end_red     = '0;
        i_end_green   = '0;
        i_end_blue    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_steps();
        test_short_lines();
        test_clip_and_replace();
        test_output_stall();
        test_random_lines(270);
        // closing stretch at full rate, no idling on either side
        idle_on = 1'b0;
        test_random_lines(60);

        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results: %0d lines loaded, %0d steps with no line",
                 requests_sent, results_seen, lines_loaded, idle_steps);
        $display("%0d pixels drawn on screen, %0d clipped off screen, %0d mismatches",
                 pixels_drawn, pixels_clipped, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
